### rtl/core/espt_pkg.sv
//------------------------------------------------------------------------------
// espt_pkg
// Shared types and constants for the escape site predictor table.
//------------------------------------------------------------------------------
`default_nettype none

package espt_pkg;

    localparam int TABLE_LOG   = 10;
    localparam int PROBE_LIMIT = 9;
    localparam int SLOTS       = 1 << TABLE_LOG;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [5:0]  FAIL_MAX  = 6'd63;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_ESCAPE = 2'd1;
    localparam logic [1:0] OP_DECAY  = 2'd2;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_HINTS     = 1'b1;

    // one table entry: key, escape count, failure count
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] count;
        logic [5:0]  fails;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_BEST_RD,
        ST_BEST_CHK,
        ST_UPDATE,
        ST_DECAY_RD,
        ST_DECAY_WR,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

### rtl/core/escape_site_predictor_table.sv
//------------------------------------------------------------------------------
// escape_site_predictor_table
// Open-addressed allocation site table with escape counting and decay.
//------------------------------------------------------------------------------
// Input words (opcode, site fields) enter on in_valid / in_stall; one result
// word per input leaves on out_valid / out_stall. Configuration registers are
// written through cfg_we / cfg_index / cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. The site
// table sits in one single-port memory (1024 entries of key, escape count and
// failure count) with a registered read. A query or escape reads and then
// checks each probe, up to 9 probes. An escape then updates the hit or empty
// slot, or re-reads and writes the victim when every probe misses. Each word
// then loads the output register and returns to idle before the next accept.
// Ignored escapes and the unused opcode go straight to the output register.
// A decay tick walks every entry, reading each and halving occupied counts.
// One word is in flight at a time; the next is taken once its result is
// loaded into the output register. A stalled result holds in the output
// register and the next result waits behind it with the input stalled.
// After reset the table is cleared by a pass over all 1024 entries, one
// entry per cycle, during which no input word is taken. Configuration resets
// to threshold 16, hints enabled.
//------------------------------------------------------------------------------
`default_nettype none

module escape_site_predictor_table
    import espt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] site_key,
    input  wire logic [63:0] site_ident,
    input  wire logic [15:0] site_bci,
    input  wire logic        heap_escape,
    input  wire logic        hint_present,
    input  wire logic        flip_allowed,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        stack_allocate,
    output      logic        flipped_to_heap,
    output      logic        slot_found,
    output      logic [TABLE_LOG-1:0] slot_index
);

    // table memory
    entry_t mem [SLOTS];
    entry_t rd_data;
    logic   mem_we;
    logic [TABLE_LOG-1:0] mem_addr;
    entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wr_data;
        end
        rd_data <= mem[mem_addr];
    end

    // config registers
    logic [15:0] thr_reg;
    logic        hints_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= 16'd16;
            hints_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_THRESHOLD)
                thr_reg <= cfg_data;
            else
                hints_reg <= cfg_data[0];
        end
    end

    // control and working registers
    state_t state_reg, state_next;
    logic [TABLE_LOG-1:0] idx_reg, idx_next, stride_reg, stride_next;
    logic [TABLE_LOG-1:0] best_reg, best_next;
    logic [31:0] best_cnt_reg, best_cnt_next;
    logic [5:0]  best_fail_reg, best_fail_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    logic [TABLE_LOG:0] walk_reg, walk_next;
    logic [63:0] key_reg, key_next;
    logic        claim_reg, claim_next;
    logic        flip_ok_reg, flip_ok_next;
    logic        victim_reg, victim_next;
    logic        stack_reg, stack_next, flip_reg, flip_next, found_reg, found_next;
    logic [TABLE_LOG-1:0] sidx_reg, sidx_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        stride_reg    <= stride_next;
        best_reg      <= best_next;
        best_cnt_reg  <= best_cnt_next;
        best_fail_reg <= best_fail_next;
        probe_reg     <= probe_next;
        key_reg       <= key_next;
        claim_reg     <= claim_next;
        flip_ok_reg   <= flip_ok_next;
        victim_reg    <= victim_next;
        stack_reg     <= stack_next;
        flip_reg      <= flip_next;
        found_reg     <= found_next;
        sidx_reg      <= sidx_next;
    end

    // escape arithmetic on the read entry
    logic [32:0] inc_sum;
    logic [31:0] cnt_inc;
    logic [31:0] add_val;
    logic [32:0] add_sum;
    logic [31:0] cnt_flip;
    logic [47:0] thr_shift;
    logic        do_flip;
    entry_t      cur;

    always_comb
    begin
        cur     = rd_data;
        if (victim_reg)
        begin
            cur.count = '0;
            cur.fails = '0;
        end
        // an evicted or empty slot takes the new key
        if (victim_reg || cur.key == 64'd0)
            cur.key = key_reg;
        inc_sum = {1'b0, cur.count} + 33'd1;
        cnt_inc = inc_sum[32] ? COUNT_MAX : inc_sum[31:0];
        thr_shift = {32'd0, thr_reg} << cur.fails[4:0];
        if (thr_reg == 16'd0)
            add_val = '0;
        else if (cur.fails >= 6'd32 || thr_shift[47:32] != 16'd0)
            add_val = COUNT_MAX;
        else
            add_val = thr_shift[31:0];
        add_sum  = {1'b0, cnt_inc} + {1'b0, add_val};
        cnt_flip = add_sum[32] ? COUNT_MAX : add_sum[31:0];
        do_flip  = (cur.count >= {16'd0, thr_reg}) && flip_ok_reg;
    end

    // next state
    logic hit, empty, better, last_probe;
    logic [TABLE_LOG-1:0] home;

    always_comb
    begin
        home       = site_ident[TABLE_LOG-1:0] ^ site_bci[TABLE_LOG-1:0];
        empty      = (rd_data.key == 64'd0);
        hit        = !empty && (rd_data.key == key_reg);
        better     = (rd_data.fails < best_fail_reg) ||
                     (rd_data.fails == best_fail_reg && rd_data.count < best_cnt_reg);
        last_probe = (probe_reg == PROBE_W'(PROBE_LIMIT - 1));
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (walk_reg == (TABLE_LOG+1)'(SLOTS - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                begin
                    if (opcode == OP_QUERY)
                        state_next = ST_PROBE_RD;
                    else if (opcode == OP_ESCAPE &&
                             heap_escape && hint_present && hints_reg)
                        state_next = ST_PROBE_RD;
                    else if (opcode == OP_DECAY)
                        state_next = ST_DECAY_RD;
                    else
                        state_next = ST_OUT;
                end
            ST_PROBE_RD:
                state_next = ST_PROBE_CHK;
            ST_PROBE_CHK:
                if (empty && !claim_reg) state_next = ST_OUT;
                else if (hit || empty)
                    state_next = claim_reg ? ST_UPDATE : ST_OUT;
                else if (last_probe)
                    state_next = claim_reg ? ST_BEST_RD : ST_OUT;
                else
                    state_next = ST_PROBE_RD;
            ST_BEST_RD:
                state_next = ST_BEST_CHK;
            ST_BEST_CHK:
                state_next = ST_OUT;
            ST_UPDATE:
                state_next = ST_OUT;
            ST_DECAY_RD:
                state_next = ST_DECAY_WR;
            ST_DECAY_WR:
                state_next = (walk_reg == (TABLE_LOG+1)'(SLOTS - 1)) ? ST_OUT : ST_DECAY_RD;
            ST_OUT:
                if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next       = idx_reg;
        stride_next    = stride_reg;
        best_next      = best_reg;
        best_cnt_next  = best_cnt_reg;
        best_fail_next = best_fail_reg;
        probe_next     = probe_reg;
        walk_next      = walk_reg;
        key_next       = key_reg;
        claim_next     = claim_reg;
        flip_ok_next   = flip_ok_reg;
        victim_next    = victim_reg;
        stack_next     = stack_reg;
        flip_next      = flip_reg;
        found_next     = found_reg;
        sidx_next      = sidx_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_addr       = idx_reg;
        wr_data        = rd_data;
        in_stall       = 1'b1;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = walk_reg[TABLE_LOG-1:0];
                wr_data   = '0;
                walk_next = (walk_reg == (TABLE_LOG+1)'(SLOTS - 1)) ? '0 : walk_reg + 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    key_next     = site_key;
                    claim_next   = (opcode == OP_ESCAPE);
                    flip_ok_next = flip_allowed;
                    victim_next  = 1'b0;
                    idx_next     = home;
                    stride_next  = home | TABLE_LOG'(1);
                    best_next    = home;
                    probe_next   = '0;
                    walk_next    = '0;
                    stack_next   = (opcode == OP_QUERY);
                    flip_next    = 1'b0;
                    found_next   = 1'b0;
                    sidx_next    = '0;
                end
            end
            ST_PROBE_RD:
                mem_addr = idx_reg;
            ST_PROBE_CHK:
            begin
                if (probe_reg == '0 || better)
                begin
                    best_next      = idx_reg;
                    best_cnt_next  = rd_data.count;
                    best_fail_next = rd_data.fails;
                end
                if (hit && !claim_reg)
                begin
                    found_next = 1'b1;
                    sidx_next  = idx_reg;
                    stack_next = rd_data.count < {16'd0, thr_reg};
                end
                else if (!(hit || empty))
                begin
                    idx_next   = idx_reg + stride_reg;
                    probe_next = probe_reg + 1'b1;
                    if (last_probe && claim_reg)
                    begin
                        idx_next    = (probe_reg == '0 || better) ? idx_reg : best_reg;
                        victim_next = 1'b1;
                    end
                end
            end
            ST_BEST_RD:
                mem_addr = idx_reg;
            ST_BEST_CHK, ST_UPDATE:
            begin
                mem_we        = 1'b1;
                mem_addr      = idx_reg;
                wr_data       = cur;
                wr_data.count = do_flip ? cnt_flip : cnt_inc;
                if (do_flip && cur.fails != FAIL_MAX)
                    wr_data.fails = cur.fails + 6'd1;
                found_next = 1'b1;
                sidx_next  = idx_reg;
                flip_next  = do_flip;
                stack_next = 1'b0;
            end
            ST_DECAY_RD:
                mem_addr = walk_reg[TABLE_LOG-1:0];
            ST_DECAY_WR:
            begin
                mem_addr = walk_reg[TABLE_LOG-1:0];
                if (rd_data.key != 64'd0)
                begin
                    mem_we        = 1'b1;
                    wr_data.count = 32'(({1'b0, rd_data.count} + 33'd1) >> 1);
                end
                walk_next = walk_reg + 1'b1;
            end
            ST_OUT:
                if (!out_valid_reg || !out_stall)
                    out_valid_next = 1'b1;
            default:
                ;
        endcase
    end

    // result word registers
    logic r_stack_reg, r_flip_reg, r_found_reg;
    logic [TABLE_LOG-1:0] r_idx_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
        begin
            r_stack_reg <= stack_reg;
            r_flip_reg  <= flip_reg;
            r_found_reg <= found_reg;
            r_idx_reg   <= sidx_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stack_allocate  = r_stack_reg;
    assign flipped_to_heap = r_flip_reg;
    assign slot_found      = r_found_reg;
    assign slot_index      = r_idx_reg;

endmodule

`default_nettype wire

### tb/tb_escape_site_predictor_table.sv
//------------------------------------------------------------------------------
// tb_escape_site_predictor_table
// Self-checking bench for the escape site predictor table.
//------------------------------------------------------------------------------
// Words are driven through the valid/stall input channel with random gaps.
// Results are taken with random stalls. A behavioral copy of the site table
// predicts every result word. Directed tests cover empty lookups, hits,
// reprobing, victim replacement, zero keys, ignored escapes, flipping with
// count and failure saturation, decay and the unused opcode. Random phases
// then run over several threshold and hint settings.
//------------------------------------------------------------------------------
`default_nettype none

module tb_escape_site_predictor_table;
    import espt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic                 stack;
        logic                 flipped;
        logic                 found;
        logic [TABLE_LOG-1:0] slot;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [63:0] site_key;
    logic [63:0] site_ident;
    logic [15:0] site_bci;
    logic        heap_escape;
    logic        hint_present;
    logic        flip_allowed;
    logic        out_valid;
    logic        out_stall;
    logic        stack_allocate;
    logic        flipped_to_heap;
    logic        slot_found;
    logic [TABLE_LOG-1:0] slot_index;

    // shadow of the site table and registers
    logic [63:0] tbl_key   [SLOTS];
    logic [31:0] tbl_count [SLOTS];
    logic [5:0]  tbl_fails [SLOTS];
    logic [15:0] threshold;
    logic        hints_on;

    result_t pending_results[$];
    int      errors = 0;
    bit      no_idle;
    bit      long_hold;
    int      idle_cycles = 0;

    // hot site pool: key and home slot
    logic [63:0] pool_key  [POOL_SIZE];
    logic [9:0]  pool_home [POOL_SIZE];

    escape_site_predictor_table DUT (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // open-addressed lookup on the shadow table
    task automatic lookup_site(input logic [63:0] key, input logic [63:0] ident,
                               input logic [15:0] bci, input bit claim,
                               output bit hit, output logic [9:0] slot);
        logic [9:0] idx;
        logic [9:0] stride;
        logic [9:0] best;
        idx = ident[9:0] ^ bci[9:0];
        stride = idx | 10'd1;
        best = idx;
        hit = 1'b0;
        slot = '0;
        for (int i = 0; i < PROBE_LIMIT; i++)
        begin
            if (tbl_key[idx] == 64'd0)
            begin
                if (!claim)
                    return;
                tbl_key[idx] = key;
            end
            if (tbl_key[idx] == key)
            begin
                hit = 1'b1;
                slot = idx;
                return;
            end
            if (tbl_fails[idx] < tbl_fails[best] ||
                (tbl_fails[idx] == tbl_fails[best] && tbl_count[idx] < tbl_count[best]))
                best = idx;
            idx = idx + stride;
        end
        if (!claim)
            return;
        // no free slot: evict the weakest probed site
        tbl_key[best] = key;
        tbl_count[best] = '0;
        tbl_fails[best] = '0;
        hit = 1'b1;
        slot = best;
    endtask

    // expected result of one accepted word, updating the shadow table
    task automatic predict_site_word(output result_t r);
        bit          hit;
        logic [9:0]  slot;
        logic [31:0] old;
        logic [5:0]  f;
        logic [63:0] add;
        logic [63:0] sum;
        r = '0;
        case (opcode)
            OP_QUERY:
            begin
                lookup_site(site_key, site_ident, site_bci, 1'b0, hit, slot);
                r.found = hit;
                r.slot = hit ? slot : '0;
                r.stack = !hit || (tbl_count[slot] < {16'd0, threshold});
            end
            OP_ESCAPE:
            begin
                if (heap_escape && hints_on && hint_present)
                begin
                    lookup_site(site_key, site_ident, site_bci, 1'b1, hit, slot);
                    r.found = 1'b1;
                    r.slot = slot;
                    old = tbl_count[slot];
                    tbl_count[slot] = (old == COUNT_MAX) ? COUNT_MAX : old + 32'd1;
                    if (old >= {16'd0, threshold} && flip_allowed)
                    begin
                        f = tbl_fails[slot];
                        tbl_fails[slot] = (f < FAIL_MAX) ? f + 6'd1 : FAIL_MAX;
                        if (threshold == 16'd0)
                            add = '0;
                        else if (f >= 6'd32)
                            add = {32'd0, COUNT_MAX};
                        else
                            add = {48'd0, threshold} << f;
                        sum = {32'd0, tbl_count[slot]} + add;
                        tbl_count[slot] = (sum > {32'd0, COUNT_MAX}) ? COUNT_MAX : sum[31:0];
                        r.flipped = 1'b1;
                    end
                end
            end
            OP_DECAY:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_key[i] != 64'd0)
                        tbl_count[i] = 32'(({1'b0, tbl_count[i]} + 33'd1) >> 1);
            end
            default: ;
        endcase
    endtask

    // send one word and record its expected result on acceptance
    task automatic send_word(input logic [1:0] op, input logic [63:0] key,
                             input logic [63:0] ident, input logic [15:0] bci,
                             input bit heap, input bit hint, input bit flip);
        int      gap;
        result_t r;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        site_key     <= key;
        site_ident   <= ident;
        site_bci     <= bci;
        heap_escape  <= heap;
        hint_present <= hint;
        flip_allowed <= flip;
        do
            @(posedge clk);
        while (in_stall);
        predict_site_word(r);
        pending_results.push_back(r);
    endtask

    // wait for the block to go idle, then write one register
    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            threshold = value;
        else
            hints_on = value[0];
    endtask

    // ident whose hash lands on a given home slot
    function automatic logic [63:0] ident_for(input logic [9:0] home, input logic [15:0] bci);
        return {$urandom(), $urandom()} & ~64'h3FF | {54'd0, home ^ bci[9:0]};
    endfunction

    task automatic test_directed_lookup();
        logic [15:0] b;
        b = 16'hFFFF;
        // query on an empty table, then claim and hit the same site
        send_word(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, b, 1, 1, 1);
        send_word(OP_ESCAPE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, b, 1, 1, 1);
        send_word(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, b, 0, 0, 0);
        // escapes that are ignored
        send_word(OP_ESCAPE, 64'h1, 64'h0, 16'h0, 0, 1, 1);
        send_word(OP_ESCAPE, 64'h1, 64'h0, 16'h0, 1, 0, 1);
        // zero key: claims an empty slot that stays empty
        send_word(OP_ESCAPE, 64'h0, 64'h0, 16'h0, 1, 1, 1);
        send_word(OP_QUERY, 64'h0, 64'h0, 16'h0, 1, 1, 1);
        // eleven sites on one home: reprobing then eviction
        for (int i = 1; i <= 11; i++)
            send_word(OP_ESCAPE, 64'h100 + i, 64'h5A, 16'h0, 1, 1, 0);
        send_word(OP_QUERY, 64'h101, 64'h5A, 16'h0, 0, 1, 1);
        send_word(OP_QUERY, 64'h10B, 64'h5A, 16'h0, 0, 1, 1);
        send_word(OP_DECAY, 64'h0, 64'h0, 16'h0, 0, 0, 0);
        send_word(OP_UNUSED, 64'h101, 64'h5A, 16'h0, 1, 1, 1);
        send_word(OP_QUERY, 64'h101, 64'h5A, 16'h0, 1, 1, 1);
    endtask

    // hammer one site until counts and failure counts saturate
    task automatic test_saturation();
        write_reg(CFG_THRESHOLD, 16'd1);
        for (int i = 0; i < 72; i++)
            send_word(OP_ESCAPE, 64'hDEAD_BEEF_0000_0001, 64'h3C3, 16'h0, 1, 1, 1);
        send_word(OP_QUERY, 64'hDEAD_BEEF_0000_0001, 64'h3C3, 16'h0, 1, 1, 1);
        send_word(OP_DECAY, 64'h0, 64'h0, 16'h0, 0, 0, 0);
        send_word(OP_QUERY, 64'hDEAD_BEEF_0000_0001, 64'h3C3, 16'h0, 1, 1, 1);
    endtask

    // random words biased toward a small pool of colliding sites
    task automatic test_random(input int count);
        int          sel;
        int          p;
        logic [1:0]  op;
        logic [63:0] key;
        logic [63:0] ident;
        logic [15:0] bci;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            op = (sel < 46) ? OP_ESCAPE : (sel < 95) ? OP_QUERY :
                 (sel < 97) ? OP_DECAY : OP_UNUSED;
            bci = 16'($urandom());
            p = $urandom_range(0, POOL_SIZE - 1);
            sel = $urandom_range(0, 99);
            if (sel < 85)
            begin
                key = pool_key[p];
                ident = ident_for(pool_home[p], bci);
            end
            else if (sel < 95)
            begin
                key = {$urandom(), $urandom()};
                ident = {$urandom(), $urandom()};
            end
            else
            begin
                key = 64'd0;
                ident = ident_for(pool_home[p], bci);
            end
            send_word(op, key, ident, bci, $urandom_range(0, 9) != 0,
                      $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
            if (n % 100 == 50)
                no_idle = !no_idle;
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        long_hold = 1'b1;
        test_random(40);
        long_hold = 1'b0;
    endtask

    // result receiver with random and long stalls
    initial
    begin
        int n;
        out_stall = 1'b1;
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 18);
            if (long_hold)
                n = 400;
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result word", $time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (stack_allocate !== want.stack)
                begin
                    $display("%0t stack_allocate exp %0d got %0d", $time, want.stack,
                             stack_allocate);
                    errors++;
                end
                if (flipped_to_heap !== want.flipped)
                begin
                    $display("%0t flipped_to_heap exp %0d got %0d", $time, want.flipped,
                             flipped_to_heap);
                    errors++;
                end
                if (slot_found !== want.found)
                begin
                    $display("%0t slot_found exp %0d got %0d", $time, want.found, slot_found);
                    errors++;
                end
                if (slot_index !== want.slot)
                begin
                    $display("%0t slot_index exp %0d got %0d", $time, want.slot, slot_index);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[escape_site_predictor_table] ERROR");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_QUERY;
        site_key = '0;
        site_ident = '0;
        site_bci = '0;
        heap_escape = 1'b0;
        hint_present = 1'b0;
        flip_allowed = 1'b0;
        no_idle = 1'b0;
        long_hold = 1'b0;
        threshold = 16'd16;
        hints_on = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_key[i] = '0;
            tbl_count[i] = '0;
            tbl_fails[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_key[i] = {$urandom(), $urandom()} | 64'd1;
            pool_home[i] = (i % 3 == 0) ? 10'd0 : (i % 3 == 1) ? 10'h3FF : 10'(i * 37);
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_lookup();
        test_saturation();
        write_reg(CFG_THRESHOLD, 16'd16);
        test_random(250);
        test_backpressure();
        write_reg(CFG_THRESHOLD, 16'd0);
        test_random(200);
        write_reg(CFG_THRESHOLD, 16'd65535);
        test_random(200);
        write_reg(CFG_HINTS, 16'd0);
        write_reg(CFG_THRESHOLD, 16'd3);
        test_random(150);
        write_reg(CFG_HINTS, 16'd1);
        test_random(300);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[escape_site_predictor_table] OK");
        else
            $display("[escape_site_predictor_table] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/core/espt_pkg.sv
rtl/core/escape_site_predictor_table.sv
tb/tb_escape_site_predictor_table.sv
